// ===== sv/kas_pkg.sv =====
package kas_pkg;

  localparam int DefQueueDepth = 8;
  localparam int DefNumAnims   = 64;
  localparam int DefFrameBits  = 9;

  localparam int IdxW    = 6;
  localparam int MsW     = 16;
  localparam int AccW    = 17;
  localparam int WeightW = 17;
  localparam int CntW    = 5;

  // blend weight of 1.0 in Q1.16
  localparam logic [WeightW-1:0] OneQ16 = 17'h10000;
  localparam logic [CntW-1:0]    DivLastStep = 5'd16;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_CHANGE = 2'd2,
    ACT_LOAD   = 2'd3
  } action_e;

  typedef struct packed {
    logic                we;
    logic [IdxW-1:0]     waddr;
    logic [IdxW-1:0]     raddr;
  } tbl_ctrl_t;

endpackage

// ===== sv/keyframe_animation_sequencer.sv =====
// channel  | handshake                  | fields
// input    | in_valid_i / in_ready_o    | action, elapsed_ms, anim_index, first/last frame,
//          |                            | frame_time_ms
// output   | out_valid_o / out_ready_i  | current/previous frame, blend_weight,
//          |                            | current_anim, playing
// load, append to a busy queue and a tick on an empty queue go from decode to done,
// change and first append through apply; a tick steps frames in the loop (through
// an advance wait and an advance state when the animation switches), then computes
// the blend weight. the frame loop and the 17-step restoring divider share one
// subtractor, and the table is a registered-read memory with separate read/write ports.
// reset clears pointers, playback state and handshake flags; no table sweep.
// a new word is taken as soon as the sequencer is idle, while a finished
// result may still wait in the output register.
module keyframe_animation_sequencer #(
  parameter int QUEUE_DEPTH = kas_pkg::DefQueueDepth,
  parameter int NUM_ANIMS   = kas_pkg::DefNumAnims,
  parameter int FRAME_BITS  = kas_pkg::DefFrameBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [kas_pkg::MsW-1:0]     elapsed_ms_i,
  input  logic [kas_pkg::IdxW-1:0]    anim_index_i,
  input  logic [FRAME_BITS-1:0]       first_frame_i,
  input  logic [FRAME_BITS-1:0]       last_frame_i,
  input  logic [kas_pkg::MsW-1:0]     frame_time_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [FRAME_BITS-1:0]       current_frame_o,
  output logic [FRAME_BITS-1:0]       previous_frame_o,
  output logic [kas_pkg::WeightW-1:0] blend_weight_o,
  output logic [kas_pkg::IdxW-1:0]    current_anim_o,
  output logic                        playing_o
);
  import kas_pkg::*;

  localparam int TblDepth = (NUM_ANIMS < 64) ? NUM_ANIMS : 64;
  localparam int QW       = $clog2(QUEUE_DEPTH);
  localparam int DW       = 2 * FRAME_BITS + MsW;
  localparam logic [QW-1:0] QLast = QW'(QUEUE_DEPTH - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_APPLY = 4'd2;
  localparam logic [3:0] S_LOOP  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_ADVW  = 4'd5;
  localparam logic [3:0] S_ADV   = 4'd6;
  localparam logic [3:0] S_DINIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]             state_q, state_d;
  action_e                act_q;
  logic [MsW-1:0]         ms_q;
  logic [IdxW-1:0]        idx_q;
  logic [FRAME_BITS-1:0]  ff_q, lf_q;
  logic [MsW-1:0]         ft_q;

  logic [IdxW-1:0]        queue_q [QUEUE_DEPTH];
  logic [QW-1:0]          rp_q, rp_d, wp_q, wp_d;
  logic [FRAME_BITS-1:0]  shown_q, shown_d, blend_q, blend_d;
  logic [MsW-1:0]         dur_q, dur_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [WeightW-1:0]     weight_q, weight_d;
  logic                   cp_q, cp_d;

  logic [AccW-1:0]        rem_q, rem_d;
  logic [MsW-1:0]         quo_q, quo_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic                   q_we;
  logic [QW-1:0]          q_waddr;

  logic                   out_valid_q;
  logic [FRAME_BITS-1:0]  out_cur_q, out_prev_q;
  logic [WeightW-1:0]     out_weight_q;
  logic [IdxW-1:0]        out_anim_q;
  logic                   out_play_q;
  logic                   out_load;

  tbl_ctrl_t              tbl_ctrl;
  logic [DW-1:0]          tbl_wdata, tbl_rdata;
  logic [FRAME_BITS-1:0]  e_first, e_last;
  logic [MsW-1:0]         e_time;

  // shared subtractor
  logic [AccW-1:0]        sub_a, sub_b, div_t;
  logic [AccW:0]          diff;
  logic                   sub_neg;

  logic                   empty, idx_ok;
  logic [QW-1:0]          rp_next, wp_next;

  function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
    ring_next = (p == QLast) ? '0 : p + 1'b1;
  endfunction

  assign empty   = (rp_q == wp_q);
  assign idx_ok  = (32'(idx_q) < NUM_ANIMS);
  assign rp_next = ring_next(rp_q);
  assign wp_next = ring_next(wp_q);

  assign e_first = tbl_rdata[DW-1 -: FRAME_BITS];
  assign e_last  = tbl_rdata[MsW +: FRAME_BITS];
  assign e_time  = tbl_rdata[MsW-1:0];

  assign tbl_ctrl.we    = (state_q == S_DEC) && (act_q == ACT_LOAD) && idx_ok;
  assign tbl_ctrl.waddr = idx_q;
  assign tbl_ctrl.raddr = (state_q == S_DEC) ? idx_q : queue_q[rp_q];
  assign tbl_wdata      = {ff_q, lf_q, (ft_q == '0) ? MsW'(1) : ft_q};

  kas_table #(
    .DEPTH (TblDepth),
    .DW    (DW)
  ) u_table (
    .clk_i   (clk_i),
    .ctrl_i  (tbl_ctrl),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  assign div_t = (cnt_q == '0) ? rem_q : {rem_q[AccW-2:0], 1'b0};

  always_comb begin
    sub_a = acc_q;
    sub_b = AccW'(dur_q);
    case (state_q)
      S_DINIT: begin
        sub_a = AccW'(dur_q);
        sub_b = acc_q;
      end
      S_DIV: begin
        sub_a = div_t;
      end
      default: begin
        sub_a = acc_q;
      end
    endcase
  end

  assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_neg = diff[AccW];

  always_comb begin
    state_d  = state_q;
    rp_d     = rp_q;
    wp_d     = wp_q;
    shown_d  = shown_q;
    blend_d  = blend_q;
    dur_d    = dur_q;
    acc_d    = acc_q;
    weight_d = weight_q;
    cp_d     = cp_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    q_we     = 1'b0;
    q_waddr  = wp_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        state_d = S_DONE;
        case (act_q)
          ACT_TICK: begin
            if (!empty) begin
              acc_d   = acc_q + AccW'(ms_q);
              state_d = S_LOOP;
            end
          end
          ACT_APPEND: begin
            if (idx_ok) begin
              if (empty) begin
                state_d = S_APPLY;
              end else begin
                q_we = 1'b1;
                wp_d = wp_next;
              end
            end
          end
          ACT_CHANGE: begin
            if (idx_ok) state_d = S_APPLY;
          end
          default: begin
          end
        endcase
      end
      S_APPLY: begin
        state_d = S_DONE;
        if (empty) begin
          blend_d  = e_first;
          shown_d  = (e_last > e_first) ? e_first + 1'b1 : e_first;
          weight_d = (act_q == ACT_CHANGE) ? OneQ16 : '0;
          dur_d    = e_time;
          acc_d    = '0;
          q_we     = 1'b1;
          wp_d     = wp_next;
        end else begin
          q_waddr = rp_next;
          q_we    = 1'b1;
          wp_d    = ring_next(rp_next);
          if (e_time < dur_q) dur_d = e_time;
        end
        if (act_q == ACT_CHANGE) cp_d = 1'b1;
      end
      S_LOOP: begin
        if (!sub_neg && diff != '0) begin
          acc_d   = diff[AccW-1:0];
          state_d = S_CHK;
        end else begin
          state_d = S_DINIT;
        end
      end
      S_CHK: begin
        if (cp_q || shown_q >= e_last) begin
          if (rp_next != wp_q) rp_d = rp_next;
          state_d = S_ADVW;
        end else begin
          dur_d   = e_time;
          blend_d = shown_q;
          shown_d = shown_q + 1'b1;
          state_d = S_LOOP;
        end
      end
      S_ADVW: begin
        // table read of the new queue head in flight
        state_d = S_ADV;
      end
      S_ADV: begin
        acc_d   = '0;
        dur_d   = e_time;
        blend_d = shown_q;
        shown_d = e_first;
        cp_d    = 1'b0;
        state_d = S_LOOP;
      end
      S_DINIT: begin
        rem_d   = diff[AccW-1:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = sub_neg ? div_t : diff[AccW-1:0];
        quo_d = {quo_q[MsW-2:0], ~sub_neg};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLastStep) begin
          weight_d = {quo_q, ~sub_neg};
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      shown_q     <= '0;
      blend_q     <= '0;
      dur_q       <= MsW'(1);
      acc_q       <= '0;
      weight_q    <= '0;
      cp_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      shown_q  <= shown_d;
      blend_q  <= blend_d;
      dur_q    <= dur_d;
      acc_q    <= acc_d;
      weight_q <= weight_d;
      cp_q     <= cp_d;
      cnt_q    <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_e'(action_i);
      ms_q  <= elapsed_ms_i;
      idx_q <= anim_index_i;
      ff_q  <= first_frame_i;
      lf_q  <= last_frame_i;
      ft_q  <= frame_time_ms_i;
    end
    if (q_we) begin
      queue_q[q_waddr] <= idx_q;
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (out_load) begin
      out_cur_q    <= shown_q;
      out_prev_q   <= blend_q;
      out_weight_q <= weight_q;
      out_anim_q   <= empty ? '0 : queue_q[rp_q];
      out_play_q   <= !empty;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign current_frame_o  = out_cur_q;
  assign previous_frame_o = out_prev_q;
  assign blend_weight_o   = out_weight_q;
  assign current_anim_o   = out_anim_q;
  assign playing_o        = out_play_q;

endmodule

// ===== sv/kas_table.sv =====
module kas_table #(
  parameter int DEPTH = 64,
  parameter int DW    = 34
) (
  input  logic                clk_i,
  input  kas_pkg::tbl_ctrl_t  ctrl_i,
  input  logic [DW-1:0]       wdata_i,
  output logic [DW-1:0]       rdata_o
);
  import kas_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[ctrl_i.waddr[AW-1:0]] <= wdata_i;
    end
    rdata_q <= mem_q[ctrl_i.raddr[AW-1:0]];
  end

  assign rdata_o = rdata_q;

endmodule
